[rtl/fmsc_pkg.sv]
`default_nettype none

package fmsc_pkg;

  localparam int NUM_SIGS = 18;
  localparam int PAT_BYTES = 12;

  localparam logic [8:0] POS_SAT = 9'd265;
  localparam logic [8:0] MIN_KNOWN_LEN = 9'd4;
  localparam logic [NUM_SIGS-1:0] ALL_LIVE = '1;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_ARCHIVE = 3'd1,
    KIND_IMAGE   = 3'd2,
    KIND_PDF     = 3'd3,
    KIND_VIDEO   = 3'd4,
    KIND_AUDIO   = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    FMT_BINARY = 5'd0,
    FMT_ZIP    = 5'd1,
    FMT_SEVENZ = 5'd2,
    FMT_GZIP   = 5'd3,
    FMT_XZ     = 5'd4,
    FMT_ZSTD   = 5'd5,
    FMT_BZIP2  = 5'd6,
    FMT_RAR    = 5'd7,
    FMT_TAR    = 5'd8,
    FMT_PNG    = 5'd9,
    FMT_JPEG   = 5'd10,
    FMT_GIF    = 5'd11,
    FMT_WEBP   = 5'd12,
    FMT_BMP    = 5'd13,
    FMT_PDF    = 5'd14,
    FMT_MP4    = 5'd15,
    FMT_MP3    = 5'd16,
    FMT_FLAC   = 5'd17
  } format_t;

  typedef struct packed {
    logic [8:0]                 start;
    logic [3:0]                 len;
    logic [0:PAT_BYTES-1][7:0]  pat;
    logic [PAT_BYTES-1:0]       care;
    logic [8:0]                 min_len;
    format_t                    fmt;
    kind_t                      kind;
  } sig_t;

  // entries in priority order, first live entry with enough length wins
  localparam sig_t SIGS [NUM_SIGS] = '{
    '{9'd0, 4'd4, '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h00F, 9'd4, FMT_ZIP, KIND_ARCHIVE},
    '{9'd0, 4'd6, '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h03F, 9'd6, FMT_SEVENZ, KIND_ARCHIVE},
    '{9'd0, 4'd2, '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h003, 9'd2, FMT_GZIP, KIND_ARCHIVE},
    '{9'd0, 4'd6, '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h03F, 9'd6, FMT_XZ, KIND_ARCHIVE},
    '{9'd0, 4'd4, '{8'h28, 8'hB5, 8'h2F, 8'hFD, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h00F, 9'd4, FMT_ZSTD, KIND_ARCHIVE},
    '{9'd0, 4'd3, '{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h007, 9'd3, FMT_BZIP2, KIND_ARCHIVE},
    // rar checks six bytes but wants seven
    '{9'd0, 4'd6, '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h03F, 9'd7, FMT_RAR, KIND_ARCHIVE},
    // tar "ustar" at offset 257
    '{9'd257, 4'd5, '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h01F, 9'd265, FMT_TAR, KIND_ARCHIVE},
    '{9'd0, 4'd8, '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A,
                    8'h1A, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h0FF, 9'd8, FMT_PNG, KIND_IMAGE},
    '{9'd0, 4'd3, '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h007, 9'd3, FMT_JPEG, KIND_IMAGE},
    '{9'd0, 4'd6, '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h03F, 9'd6, FMT_GIF, KIND_IMAGE},
    '{9'd0, 4'd6, '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h03F, 9'd6, FMT_GIF, KIND_IMAGE},
    // riff header, size bytes are don't care
    '{9'd0, 4'd12, '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h57, 8'h45, 8'h42, 8'h50},
      12'hF0F, 9'd12, FMT_WEBP, KIND_IMAGE},
    '{9'd0, 4'd2, '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h003, 9'd2, FMT_BMP, KIND_IMAGE},
    '{9'd0, 4'd4, '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h00F, 9'd4, FMT_PDF, KIND_PDF},
    // "ftyp" at offset 4
    '{9'd4, 4'd4, '{8'h66, 8'h74, 8'h79, 8'h70, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h00F, 9'd12, FMT_MP4, KIND_VIDEO},
    '{9'd0, 4'd3, '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h007, 9'd3, FMT_MP3, KIND_AUDIO},
    '{9'd0, 4'd4, '{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      12'h00F, 9'd4, FMT_FLAC, KIND_AUDIO}
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind_code;
    logic [4:0] format_code;
    logic       archive_flag;
    logic       media_flag;
  } out_item_t;

  typedef struct packed {
    logic [NUM_SIGS-1:0] live_flags;
    logic [8:0]          length;
  } match_status_t;

  function automatic logic sig_mismatch(input sig_t s, input logic [8:0] pos,
                                        input logic [7:0] b);
    logic [8:0] off;
    logic [3:0] idx;
    logic       hit;
    hit = 1'b0;
    off = pos - s.start;
    idx = off[3:0];
    if (pos >= s.start) begin
      if (off < {5'd0, s.len}) begin
        hit = s.care[idx] && (s.pat[idx] != b);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[rtl/fmsc_stream_if.sv]
`default_nettype none

interface fmsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/fmsc_matcher.sv]
`default_nettype none

module fmsc_matcher (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  consume,
  input  wire fmsc_pkg::in_item_t    item,
  output fmsc_pkg::match_status_t    status
);

  logic [8:0]                    byte_position;
  logic [fmsc_pkg::NUM_SIGS-1:0] live_signature_flags;
  logic [fmsc_pkg::NUM_SIGS-1:0] flags_next;
  logic [8:0]                    length_next;

  always_comb begin
    flags_next = live_signature_flags;
    if (byte_position < fmsc_pkg::POS_SAT) begin
      for (int k = 0; k < fmsc_pkg::NUM_SIGS; k++) begin
        if (fmsc_pkg::sig_mismatch(fmsc_pkg::SIGS[k], byte_position, item.byte_value)) begin
          flags_next[k] = 1'b0;
        end
      end
    end
    length_next = (byte_position < fmsc_pkg::POS_SAT) ? byte_position + 9'd1
                                                      : fmsc_pkg::POS_SAT;
  end

  assign status.live_flags = flags_next;
  assign status.length     = length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      live_signature_flags <= fmsc_pkg::ALL_LIVE;
    end else if (consume) begin
      if (item.last_byte) begin
        // buffer done, start over for the next one
        byte_position        <= '0;
        live_signature_flags <= fmsc_pkg::ALL_LIVE;
      end else begin
        byte_position        <= length_next;
        live_signature_flags <= flags_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/fmsc_select.sv]
`default_nettype none

module fmsc_select (
  input  wire fmsc_pkg::match_status_t status,
  output fmsc_pkg::out_item_t          result
);

  fmsc_pkg::kind_t   kind;
  fmsc_pkg::format_t fmt;

  always_comb begin
    kind = fmsc_pkg::KIND_UNKNOWN;
    fmt  = fmsc_pkg::FMT_BINARY;
    if (status.length >= fmsc_pkg::MIN_KNOWN_LEN) begin
      // scan from the bottom so the lowest live entry wins
      for (int k = fmsc_pkg::NUM_SIGS - 1; k >= 0; k--) begin
        if (status.live_flags[k] && (status.length >= fmsc_pkg::SIGS[k].min_len)) begin
          kind = fmsc_pkg::SIGS[k].kind;
          fmt  = fmsc_pkg::SIGS[k].fmt;
        end
      end
    end
  end

  assign result.kind_code    = kind;
  assign result.format_code  = fmt;
  assign result.archive_flag = (kind == fmsc_pkg::KIND_ARCHIVE);
  assign result.media_flag   = (kind == fmsc_pkg::KIND_IMAGE) ||
                               (kind == fmsc_pkg::KIND_VIDEO) ||
                               (kind == fmsc_pkg::KIND_AUDIO);

endmodule

`default_nettype wire

[rtl/file_magic_signature_classifier.sv]
`default_nettype none

// Classifies a buffer by its magic number. Send the buffer one byte per
// transaction from offset zero, with last_byte set on the final byte; one
// result transaction follows each final byte, and no other byte gives one.
// A byte goes from an input register through the signature compare and
// priority pick into the result register, so one byte is taken every cycle
// but for the only stall: a final byte waits while the result register
// still holds an untaken result. A final byte's result is written to the
// result register as the byte leaves the input register. Buffers shorter
// than four bytes report unknown; bytes past offset 264 are never compared.
module file_magic_signature_classifier (
  input  wire logic clk,
  input  wire logic rst,
  fmsc_stream_if.sink   in_ch,
  fmsc_stream_if.source out_ch
);

  logic                    s1_valid;
  fmsc_pkg::in_item_t      s1_item;
  logic                    out_valid;
  fmsc_pkg::out_item_t     out_item;
  logic                    out_free;
  logic                    s1_go;
  fmsc_pkg::match_status_t status;
  fmsc_pkg::out_item_t     result;

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_go       = s1_valid && (!s1_item.last_byte || out_free);
  assign in_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= in_ch.payload;
    end
  end

  fmsc_matcher u_matcher (
    .clk     (clk),
    .rst     (rst),
    .consume (s1_go),
    .item    (s1_item),
    .status  (status)
  );

  fmsc_select u_select (
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.last_byte) begin
      out_item <= result;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

`default_nettype wire

[tb/sv/file_magic_signature_classifier_tb.sv]
`default_nettype none

module file_magic_signature_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIG_COUNT    = 18;
  localparam int SAT_LEN      = 265;
  localparam int SHORT_LIMIT  = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;

  // signature entries, in priority order
  localparam int M_ZIP   = 0;
  localparam int M_7Z    = 1;
  localparam int M_GZIP  = 2;
  localparam int M_XZ    = 3;
  localparam int M_ZSTD  = 4;
  localparam int M_BZIP2 = 5;
  localparam int M_RAR   = 6;
  localparam int M_TAR   = 7;
  localparam int M_PNG   = 8;
  localparam int M_JPEG  = 9;
  localparam int M_GIF87 = 10;
  localparam int M_GIF89 = 11;
  localparam int M_WEBP  = 12;
  localparam int M_BMP   = 13;
  localparam int M_PDF   = 14;
  localparam int M_MP4   = 15;
  localparam int M_MP3   = 16;
  localparam int M_FLAC  = 17;

  logic clk = 1'b0;
  logic rst;

  fmsc_stream_if #(.payload_t(fmsc_pkg::in_item_t))  in_ch ();
  fmsc_stream_if #(.payload_t(fmsc_pkg::out_item_t)) out_ch ();

  file_magic_signature_classifier uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // signature table
  int                magic_start [SIG_COUNT];
  int                magic_len   [SIG_COUNT];
  logic [95:0]       magic_pat   [SIG_COUNT];
  logic [11:0]       magic_care  [SIG_COUNT];
  int                magic_min   [SIG_COUNT];
  fmsc_pkg::format_t magic_fmt   [SIG_COUNT];

  // pattern is right aligned, byte 0 is the most significant of len bytes
  function automatic void set_magic(int k, int start, int len, logic [95:0] pat,
                                    logic [11:0] care, int min_len,
                                    fmsc_pkg::format_t fmt);
    magic_start[k] = start;
    magic_len[k]   = len;
    magic_pat[k]   = pat;
    magic_care[k]  = care;
    magic_min[k]   = min_len;
    magic_fmt[k]   = fmt;
  endfunction

  function automatic logic [7:0] magic_byte(int k, int i);
    return magic_pat[k][(magic_len[k] - 1 - i) * 8 +: 8];
  endfunction

  function automatic void load_magic_table();
    set_magic(M_ZIP,   0,   4,  96'h504B0304,     12'h00F, 4,   fmsc_pkg::FMT_ZIP);
    set_magic(M_7Z,    0,   6,  96'h377ABCAF271C, 12'h03F, 6,   fmsc_pkg::FMT_SEVENZ);
    set_magic(M_GZIP,  0,   2,  96'h1F8B,         12'h003, 2,   fmsc_pkg::FMT_GZIP);
    set_magic(M_XZ,    0,   6,  96'hFD377A585A00, 12'h03F, 6,   fmsc_pkg::FMT_XZ);
    set_magic(M_ZSTD,  0,   4,  96'h28B52FFD,     12'h00F, 4,   fmsc_pkg::FMT_ZSTD);
    set_magic(M_BZIP2, 0,   3,  96'h425A68,       12'h007, 3,   fmsc_pkg::FMT_BZIP2);
    set_magic(M_RAR,   0,   6,  96'h526172211A07, 12'h03F, 7,   fmsc_pkg::FMT_RAR);
    set_magic(M_TAR,   257, 5,  96'h7573746172,   12'h01F, 265, fmsc_pkg::FMT_TAR);
    set_magic(M_PNG,   0,   8,  96'h89504E470D0A1A0A, 12'h0FF, 8,
              fmsc_pkg::FMT_PNG);
    set_magic(M_JPEG,  0,   3,  96'hFFD8FF,       12'h007, 3,   fmsc_pkg::FMT_JPEG);
    set_magic(M_GIF87, 0,   6,  96'h474946383761, 12'h03F, 6,   fmsc_pkg::FMT_GIF);
    set_magic(M_GIF89, 0,   6,  96'h474946383961, 12'h03F, 6,   fmsc_pkg::FMT_GIF);
    // riff size field is not compared
    set_magic(M_WEBP,  0,   12, 96'h524946460000000057454250, 12'hF0F, 12,
              fmsc_pkg::FMT_WEBP);
    set_magic(M_BMP,   0,   2,  96'h424D,         12'h003, 2,   fmsc_pkg::FMT_BMP);
    set_magic(M_PDF,   0,   4,  96'h25504446,     12'h00F, 4,   fmsc_pkg::FMT_PDF);
    set_magic(M_MP4,   4,   4,  96'h66747970,     12'h00F, 12,  fmsc_pkg::FMT_MP4);
    set_magic(M_MP3,   0,   3,  96'h494433,       12'h007, 3,   fmsc_pkg::FMT_MP3);
    set_magic(M_FLAC,  0,   4,  96'h664C6143,     12'h00F, 4,   fmsc_pkg::FMT_FLAC);
  endfunction

  function automatic fmsc_pkg::kind_t format_kind(fmsc_pkg::format_t f);
    case (f)
      fmsc_pkg::FMT_ZIP, fmsc_pkg::FMT_SEVENZ, fmsc_pkg::FMT_GZIP, fmsc_pkg::FMT_XZ,
      fmsc_pkg::FMT_ZSTD, fmsc_pkg::FMT_BZIP2, fmsc_pkg::FMT_RAR, fmsc_pkg::FMT_TAR:
        return fmsc_pkg::KIND_ARCHIVE;
      fmsc_pkg::FMT_PNG, fmsc_pkg::FMT_JPEG, fmsc_pkg::FMT_GIF, fmsc_pkg::FMT_WEBP,
      fmsc_pkg::FMT_BMP:
        return fmsc_pkg::KIND_IMAGE;
      fmsc_pkg::FMT_PDF: return fmsc_pkg::KIND_PDF;
      fmsc_pkg::FMT_MP4: return fmsc_pkg::KIND_VIDEO;
      fmsc_pkg::FMT_MP3, fmsc_pkg::FMT_FLAC: return fmsc_pkg::KIND_AUDIO;
      default: return fmsc_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  // classifier state mirror
  logic [8:0]           scan_pos  = '0;
  logic [SIG_COUNT-1:0] live_sigs = '1;
  fmsc_pkg::out_item_t  verdicts_due[$];

  function automatic void classify_byte(logic [7:0] b, logic last);
    int                  off;
    int                  seen;
    fmsc_pkg::format_t   fm;
    fmsc_pkg::kind_t     kd;
    fmsc_pkg::out_item_t v;
    fm = fmsc_pkg::FMT_BINARY;
    if (scan_pos < SAT_LEN) begin
      for (int k = 0; k < SIG_COUNT; k++) begin
        off = int'(scan_pos) - magic_start[k];
        if (off >= 0 && off < magic_len[k] && magic_care[k][off] &&
            magic_byte(k, off) != b)
          live_sigs[k] = 1'b0;
      end
      seen = scan_pos + 1;
    end else begin
      seen = SAT_LEN;
    end
    if (!last) begin
      scan_pos = seen[8:0];
      return;
    end
    if (seen >= SHORT_LIMIT) begin
      for (int k = 0; k < SIG_COUNT && fm == fmsc_pkg::FMT_BINARY; k++)
        if (live_sigs[k] && seen >= magic_min[k]) fm = magic_fmt[k];
    end
    kd = format_kind(fm);
    v.kind_code    = kd;
    v.format_code  = fm;
    v.archive_flag = (kd == fmsc_pkg::KIND_ARCHIVE);
    v.media_flag   = kd inside {fmsc_pkg::KIND_IMAGE, fmsc_pkg::KIND_VIDEO,
                                fmsc_pkg::KIND_AUDIO};
    verdicts_due.push_back(v);
    scan_pos  = '0;
    live_sigs = '1;
  endfunction

  // result checking
  int fail_count = 0;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    fmsc_pkg::out_item_t want;
    fmsc_pkg::out_item_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (verdicts_due.size() == 0) begin
        $error("result transaction with none pending: kind_code %0d format_code %0d",
               got.kind_code, got.format_code);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        check_field("kind_code", want.kind_code, got.kind_code);
        check_field("format_code", want.format_code, got.format_code);
        check_field("archive_flag", want.archive_flag, got.archive_flag);
        check_field("media_flag", want.media_flag, got.media_flag);
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  int rx_idle_pct   = 0;
  int hold_requests = 0;

  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // byte side
  int         tx_idle_pct = 0;
  int         bytes_sent  = 0;
  logic [7:0] frame[$];

  task automatic send_byte(logic [7:0] b, logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{byte_value: b, last_byte: last};
    do @(posedge clk); while (!in_ch.ready);
    classify_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  function automatic void fill_random(int len);
    frame.delete();
    repeat (len) frame.push_back(8'($urandom));
  endfunction

  function automatic void overlay_magic(int k);
    for (int i = 0; i < magic_len[k]; i++)
      if (magic_care[k][i] && magic_start[k] + i < frame.size())
        frame[magic_start[k] + i] = magic_byte(k, i);
  endfunction

  // flip one bit of one compared byte
  function automatic void corrupt_magic(int k);
    int i;
    do i = $urandom_range(magic_len[k] - 1); while (!magic_care[k][i]);
    if (magic_start[k] + i < frame.size())
      frame[magic_start[k] + i] ^= 8'(1 << $urandom_range(7));
  endfunction

  task automatic test_each_signature();
    for (int k = 0; k < SIG_COUNT; k++) begin
      if (k == M_TAR) continue;
      fill_random(magic_min[k] < SHORT_LIMIT ? SHORT_LIMIT : magic_min[k]);
      overlay_magic(k);
      send_frame();
    end
  endtask

  task automatic test_short_buffers();
    fill_random(2); overlay_magic(M_GZIP);  send_frame();
    fill_random(3); overlay_magic(M_BMP);   send_frame();
    fill_random(3); overlay_magic(M_JPEG);  send_frame();
    fill_random(3); overlay_magic(M_BZIP2); send_frame();
    frame = {8'hFF}; send_frame();
    frame = {8'h00, 8'h00, 8'h00, 8'h00}; send_frame();
    frame = {8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_frame();
  endtask

  task automatic test_length_rules();
    // rar matches on six bytes but needs seven
    fill_random(6);  overlay_magic(M_RAR);  send_frame();
    fill_random(7);  overlay_magic(M_RAR);  send_frame();
    fill_random(11); overlay_magic(M_WEBP); send_frame();
    fill_random(7);  overlay_magic(M_PNG);  send_frame();
    fill_random(8);  overlay_magic(M_MP4);  send_frame();
    fill_random(11); overlay_magic(M_MP4);  send_frame();
    fill_random(4);  overlay_magic(M_ZIP);  corrupt_magic(M_ZIP); send_frame();
  endtask

  task automatic test_priority_overlaps();
    int firsts[4] = '{M_ZIP, M_GZIP, M_BMP, M_WEBP};
    foreach (firsts[i]) begin
      fill_random(12);
      overlay_magic(firsts[i]);
      overlay_magic(M_MP4);
      send_frame();
    end
  endtask

  task automatic test_long_buffers();
    fill_random(SAT_LEN);     overlay_magic(M_TAR); send_frame();
    fill_random(SAT_LEN - 1); overlay_magic(M_TAR); send_frame();
    fill_random(280);         overlay_magic(M_TAR); send_frame();
    fill_random(SAT_LEN);     overlay_magic(M_TAR); corrupt_magic(M_TAR); send_frame();
  endtask

  function automatic void make_random_frame();
    int mode;
    int k;
    int len;
    mode = $urandom_range(9);
    k = $urandom_range(SIG_COUNT - 1);
    // tar frames are long, keep them occasional
    if (k == M_TAR && $urandom_range(4) != 0) k = $urandom_range(M_RAR);
    if (mode <= 5) begin
      if (k == M_TAR) len = SAT_LEN - 2 + $urandom_range(30);
      else if ($urandom_range(3) == 0) len = $urandom_range(magic_min[k], 1);
      else len = magic_min[k] + $urandom_range(12);
      fill_random(len);
      overlay_magic(k);
      if ($urandom_range(3) == 0) corrupt_magic(k);
    end else if (mode <= 7) begin
      fill_random($urandom_range(16, 1));
    end else if (mode == 8) begin
      fill_random(12 + $urandom_range(4));
      overlay_magic(k == M_TAR ? M_ZIP : k);
      overlay_magic(M_MP4);
    end else begin
      fill_random($urandom_range(3) == 0 ? $urandom_range(320, 266) : $urandom_range(3, 1));
    end
  endfunction

  task automatic test_random_buffers(int tx_pct, int rx_pct, int budget);
    int first;
    first = bytes_sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (bytes_sent - first < budget) begin
      make_random_frame();
      send_frame();
    end
  endtask

  // result side holds off while short buffers keep coming, input must stall
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (30) begin
      fill_random(4);
      overlay_magic($urandom_range(1) ? M_ZIP : M_PDF);
      send_frame();
    end
  endtask

  initial begin
    load_magic_table();
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    tx_idle_pct = 22;
    rx_idle_pct <= 60;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_signature();
    test_short_buffers();
    test_length_rules();
    test_priority_overlaps();
    test_long_buffers();
    test_random_buffers(22, 60, 150);
    test_random_buffers(60, 22, 150);
    test_random_buffers(0, 0, 150);
    test_output_backpressure();

    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
